/* sv/efr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants of the escaped frame receiver: field widths,
// register indexes, register reset values and the message descriptor.
// ----------------------------------------------------------------------------
package efr_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 7;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MASK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT  = 3'd4;

	// register reset values
	localparam logic [BYTE_W-1:0] RST_START_MARKER = 8'd2;
	localparam logic [BYTE_W-1:0] RST_END_MARKER   = 8'd3;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE  = 8'd27;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_MASK  = 8'd32;
	localparam logic [LEN_W-1:0]  RST_FRAME_LIMIT  = 7'd64;

	// one completed message waiting for read-out
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		logic [CNT_W-1:0] msg_count;
		logic [CNT_W-1:0] ovr_count;
	} desc_t;

endpackage

/* sv/efr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while no read is issued.
// ----------------------------------------------------------------------------
module efr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/efr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_front
// Configuration registers and the byte classifier: strips start, end and
// escape framing, writes payload bytes into the current buffer half and
// hands each completed message to the read-out queue.
// ----------------------------------------------------------------------------
module efr_front #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [efr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [efr_pkg::BYTE_W-1:0]            cfg_data,
	input  logic                                  rx_valid,
	output logic                                  rx_ready,
	input  logic [efr_pkg::BYTE_W-1:0]            rx_byte,
	input  logic                                  q_full,
	output logic                                  q_push,
	output efr_pkg::desc_t                        q_desc,
	output logic                                  ram_we,
	output logic [$clog2(STORE_DEPTH):0]          ram_waddr,
	output logic [efr_pkg::BYTE_W-1:0]            ram_wdata
);

	import efr_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [LEN_W-1:0] DEPTH_LIM = LEN_W'(STORE_DEPTH);

	logic [BYTE_W-1:0] start_marker_q;
	logic [BYTE_W-1:0] end_marker_q;
	logic [BYTE_W-1:0] escape_byte_q;
	logic [BYTE_W-1:0] escape_mask_q;
	logic [LEN_W-1:0]  frame_limit_q;

	logic [CW-1:0]    fill_q, fill_d;
	logic             open_q, open_d;
	logic             esc_q, esc_d;
	logic             bank_q, bank_d;
	logic [CNT_W-1:0] msg_q, msg_d;
	logic [CNT_W-1:0] ovr_q, ovr_d;

	logic              rx_fire;
	logic              store_req;
	logic [BYTE_W-1:0] store_data;
	logic [LEN_W-1:0]  limit;
	logic              can_store;

	assign cfg_ready = 1'b1;
	assign rx_ready  = !q_full;
	assign rx_fire   = rx_valid && rx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= RST_START_MARKER;
			end_marker_q   <= RST_END_MARKER;
			escape_byte_q  <= RST_ESCAPE_BYTE;
			escape_mask_q  <= RST_ESCAPE_MASK;
			frame_limit_q  <= RST_FRAME_LIMIT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER:   end_marker_q   <= cfg_data;
				REG_ESCAPE_BYTE:  escape_byte_q  <= cfg_data;
				REG_ESCAPE_MASK:  escape_mask_q  <= cfg_data;
				REG_FRAME_LIMIT:  frame_limit_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// a limit above the buffer depth acts as the depth
	assign limit     = (frame_limit_q > DEPTH_LIM) ? DEPTH_LIM : frame_limit_q;
	assign can_store = LEN_W'(fill_q) < limit;

	always_comb begin
		esc_d      = esc_q;
		open_d     = open_q;
		fill_d     = fill_q;
		bank_d     = bank_q;
		msg_d      = msg_q;
		ovr_d      = ovr_q;
		store_req  = 1'b0;
		store_data = rx_byte;
		q_push     = 1'b0;
		ram_we     = 1'b0;
		if (rx_fire) begin
			if (esc_q) begin
				// escaped byte is stored even outside a frame
				esc_d      = 1'b0;
				store_req  = 1'b1;
				store_data = rx_byte ^ escape_mask_q;
			end else if (rx_byte == start_marker_q) begin
				open_d = 1'b1;
				fill_d = '0;
			end else if (rx_byte == end_marker_q) begin
				if (open_q && (fill_q != '0)) begin
					msg_d  = msg_q + CNT_W'(1);
					q_push = 1'b1;
					bank_d = !bank_q;
				end
				open_d = 1'b0;
				fill_d = '0;
			end else if (rx_byte == escape_byte_q) begin
				esc_d = 1'b1;
			end else if (open_q) begin
				store_req = 1'b1;
			end
		end
		if (store_req) begin
			if (can_store) begin
				ram_we = 1'b1;
				fill_d = fill_q + CW'(1);
			end else begin
				// overrun drops the frame
				ovr_d  = ovr_q + CNT_W'(1);
				fill_d = '0;
				open_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			open_q <= 1'b0;
			esc_q  <= 1'b0;
			bank_q <= 1'b0;
			msg_q  <= '0;
			ovr_q  <= '0;
		end else begin
			fill_q <= fill_d;
			open_q <= open_d;
			esc_q  <= esc_d;
			bank_q <= bank_d;
			msg_q  <= msg_d;
			ovr_q  <= ovr_d;
		end
	end

	assign q_desc.bank      = bank_q;
	assign q_desc.len       = LEN_W'(fill_q);
	assign q_desc.msg_count = msg_q + CNT_W'(1);
	assign q_desc.ovr_count = ovr_q;

	assign ram_waddr = {bank_q, fill_q[AW-1:0]};
	assign ram_wdata = store_data;

endmodule

/* sv/efr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_queue
// Two-entry descriptor queue between classifier and read-out, one entry per
// buffer half. An entry leaves once its last byte read has been issued.
// ----------------------------------------------------------------------------
module efr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  efr_pkg::desc_t push_desc,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output efr_pkg::desc_t head_desc
);

	import efr_pkg::*;

	desc_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_desc  = entry_q[rd_ptr_q];

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("descriptor pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("descriptor popped from empty queue");

endmodule

/* sv/efr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_back
// Message read-out: walks the head descriptor's buffer half one byte a cycle
// while msg_ready allows, via the registered RAM read and an output register.
// ----------------------------------------------------------------------------
module efr_back #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  efr_pkg::desc_t                 q_desc,
	output logic                           q_pop,
	output logic                           ram_re,
	output logic [$clog2(STORE_DEPTH):0]   ram_raddr,
	input  logic [efr_pkg::BYTE_W-1:0]     ram_rdata,
	output logic                           msg_valid,
	input  logic                           msg_ready,
	output logic [efr_pkg::BYTE_W-1:0]     payload_byte,
	output logic                           last_of_message,
	output logic [efr_pkg::LEN_W-1:0]      message_length,
	output logic [efr_pkg::CNT_W-1:0]      messages_done,
	output logic [efr_pkg::CNT_W-1:0]      overruns_seen
);

	import efr_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	logic [AW-1:0] k_q;
	logic          issue;
	logic          last_rd;
	logic          move;

	// stage 1: read in flight, data sits in the RAM read register
	logic             valid_s1;
	logic             last_s1;
	logic [LEN_W-1:0] len_s1;
	logic [CNT_W-1:0] msg_s1;
	logic [CNT_W-1:0] ovr_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic [LEN_W-1:0]  len_q;
	logic [CNT_W-1:0]  msg_q;
	logic [CNT_W-1:0]  ovr_q;

	assign move    = valid_s1 && (!out_valid_q || msg_ready);
	assign issue   = q_valid && (!valid_s1 || move);
	assign last_rd = (LEN_W'(k_q) + LEN_W'(1)) == q_desc.len;

	assign q_pop     = issue && last_rd;
	assign ram_re    = issue;
	assign ram_raddr = {q_desc.bank, k_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= last_rd ? '0 : k_q + AW'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (msg_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= last_rd;
			len_s1  <= q_desc.len;
			msg_s1  <= q_desc.msg_count;
			ovr_s1  <= q_desc.ovr_count;
		end
		if (move) begin
			byte_q <= ram_rdata;
			last_q <= last_s1;
			len_q  <= len_s1;
			msg_q  <= msg_s1;
			ovr_q  <= ovr_s1;
		end
	end

	assign msg_valid       = out_valid_q;
	assign payload_byte    = byte_q;
	assign last_of_message = last_q;
	assign message_length  = len_q;
	assign messages_done   = msg_q;
	assign overruns_seen   = ovr_q;

	// a stalled read must not be overwritten in the RAM read register
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move |=> $stable(ram_rdata))
		else $error("pending read data lost");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (LEN_W'(k_q) < q_desc.len))
		else $error("read index past message length");

endmodule

/* sv/escaped_frame_receiver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_core
// Byte-stuffing deframer with start, end and escape bytes. A classifier
// fills one half of a two-half message buffer; completed messages queue for
// read-out, which emits one byte per item with the last one marked.
// ----------------------------------------------------------------------------
// one rx item per cycle; rx_ready drops only while both buffer halves hold
// completed messages not yet read out
// with the read-out idle, a message's first byte passes the queue entry, RAM
// read register and output register once its end byte is accepted, then one
// byte per cycle while msg_ready is high (the single RAM read port sets this)
// reset clears control state and counters and loads register defaults;
// the message buffer needs no clearing pass
module escaped_frame_receiver_core #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [efr_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [efr_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          msg_valid,
	input  logic                          msg_ready,
	output logic [efr_pkg::BYTE_W-1:0]    payload_byte,
	output logic                          last_of_message,
	output logic [efr_pkg::LEN_W-1:0]     message_length,
	output logic [efr_pkg::CNT_W-1:0]     messages_done,
	output logic [efr_pkg::CNT_W-1:0]     overruns_seen
);

	import efr_pkg::*;

	localparam int ADDR_W    = $clog2(STORE_DEPTH) + 1;
	localparam int RAM_DEPTH = 2 * (2 ** $clog2(STORE_DEPTH));

	logic              q_full;
	logic              q_push;
	desc_t             push_desc;
	logic              q_pop;
	logic              q_valid;
	desc_t             head_desc;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	efr_front #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (push_desc),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	efr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (push_desc),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_desc  (head_desc)
	);

	efr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	efr_back #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_desc          (head_desc),
		.q_pop           (q_pop),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.msg_valid       (msg_valid),
		.msg_ready       (msg_ready),
		.payload_byte    (payload_byte),
		.last_of_message (last_of_message),
		.message_length  (message_length),
		.messages_done   (messages_done),
		.overruns_seen   (overruns_seen)
	);

endmodule
